FILE: hdl/mcmp_pkg.sv
// Shared constants and types of the MIDI channel message parser.
package mcmp_pkg;

   localparam logic [7:0] STATUS_BIT = 8'h80;
   localparam logic [7:0] SYS_FIRST  = 8'hF0;
   localparam logic [7:0] RT_FIRST   = 8'hF8;
   localparam logic [2:0] ONE_DATA_TYPE = 3'b110;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] first_data;
      logic [6:0] second_data;
   } mcmp_msg_type;

endpackage

FILE: hdl/mcmp_parse.sv
// Running status state and per-byte decode of the MIDI channel message parser.
module mcmp_parse import mcmp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   rx_byte,
   input  logic         fire,
   output logic         emit,
   output mcmp_msg_type msg
);

   logic [7:0] running_status_ff, running_status_in;
   logic [1:0] data_count_ff, data_count_in;
   logic [6:0] held_first_data_ff, held_first_data_in;

   logic is_rt, is_voice, is_sys, is_data, rs_voice, one_data;

   always_comb begin
      is_rt    = rx_byte >= RT_FIRST;
      is_voice = (rx_byte >= STATUS_BIT) && (rx_byte < SYS_FIRST);
      is_sys   = (rx_byte >= SYS_FIRST) && !is_rt;
      is_data  = rx_byte < STATUS_BIT;
      rs_voice = (running_status_ff >= STATUS_BIT) && (running_status_ff < SYS_FIRST);
      one_data = running_status_ff[7:5] == ONE_DATA_TYPE;
      emit     = is_data && rs_voice && (one_data || (data_count_ff != 2'd0));

      msg.status_byte = running_status_ff;
      if (one_data) begin
         msg.first_data  = rx_byte[6:0];
         msg.second_data = 7'd0;
      end else begin
         msg.first_data  = held_first_data_ff;
         msg.second_data = rx_byte[6:0];
      end

      running_status_in  = running_status_ff;
      data_count_in      = data_count_ff;
      held_first_data_in = held_first_data_ff;
      if (is_voice) begin
         running_status_in = rx_byte;
         data_count_in     = 2'd0;
      end else if (is_sys) begin
         running_status_in = 8'd0;
         data_count_in     = 2'd0;
      end else if (is_data && rs_voice) begin
         if (!one_data && (data_count_ff == 2'd0)) begin
            held_first_data_in = rx_byte[6:0];
            data_count_in      = 2'd1;
         end else begin
            data_count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff  <= 8'd0;
         data_count_ff      <= 2'd0;
         held_first_data_ff <= 7'd0;
      end else if (fire) begin
         running_status_ff  <= running_status_in;
         data_count_ff      <= data_count_in;
         held_first_data_ff <= held_first_data_in;
      end
   end

endmodule

FILE: hdl/mcmp_out_reg.sv
// Result register of the MIDI channel message parser.
module mcmp_out_reg import mcmp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  mcmp_msg_type msg,
   output logic         free,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output mcmp_msg_type rsp_msg
);

   logic         valid_ff, valid_in;
   mcmp_msg_type msg_ff;

   always_comb begin
      free     = !valid_ff || rsp_ready;
      valid_in = load || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         msg_ff <= msg;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_msg   = msg_ff;

endmodule

FILE: hdl/midi_channel_message_parser_unit.sv
// Top level of the MIDI channel message parser with running status.
// One received MIDI byte is taken per item and a complete channel voice message comes out once
// its last data byte has been seen; real-time bytes are ignored, system bytes clear the running
// status and stray data bytes are dropped. A byte is accepted in every cycle unless a message
// waits for a full result register: it passes an input register, is decoded combinationally
// against the running status and lands in the result register. The result register holds a
// message while the consumer stalls, and bytes that produce no message keep flowing meanwhile.
module midi_channel_message_parser_unit import mcmp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_status_byte,
   output logic [6:0] rsp_first_data,
   output logic [6:0] rsp_second_data
);

   logic         s1_valid_ff, s1_valid_in;
   logic [7:0]   s1_byte_ff;
   logic         s1_consume, emit, out_free;
   mcmp_msg_type msg, rsp_msg;

   mcmp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .rx_byte (s1_byte_ff),
      .fire    (s1_consume),
      .emit    (emit),
      .msg     (msg)
   );

   mcmp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_consume && emit),
      .msg       (msg),
      .free      (out_free),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_msg   (rsp_msg)
   );

   always_comb begin
      s1_consume  = s1_valid_ff && (!emit || out_free);
      req_ready   = !s1_valid_ff || s1_consume;
      s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_consume);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_rx_byte;
      end
   end

   assign rsp_status_byte = rsp_msg.status_byte;
   assign rsp_first_data  = rsp_msg.first_data;
   assign rsp_second_data = rsp_msg.second_data;

endmodule
